FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion helpers
// shared concurrent assertion forms for the core rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/tpcs_pkg.sv
// ----------------------------------------------------------------------------
// tpcs_pkg
// types, constants and the restoring division step for the coordinate scaler
// ----------------------------------------------------------------------------
package tpcs_pkg;

   localparam int COORD_W = 14;
   localparam int SCREEN_W = 10;
   localparam int NUMER_W = 2 * COORD_W;
   localparam int DIV_STEPS = COORD_W;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;
   localparam int BTN_W = 3;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [SCREEN_W-1:0] screen_type;
   typedef logic [NUMER_W-1:0] numer_type;
   typedef logic [BTN_W-1:0] btn_type;

   localparam coord_type ABS_FULL = 14'd16383;
   localparam coord_type BORDER_RESET = 14'd100;
   localparam coord_type MAX_RESET = 14'd16383;
   localparam screen_type COLS_RESET = 10'd80;
   localparam screen_type ROWS_RESET = 10'd25;

   typedef enum logic [2:0] {
      CSR_BORDER = 3'd0,
      CSR_MAX_X = 3'd1,
      CSR_MAX_Y = 3'd2,
      CSR_SCREEN_COLS = 3'd3,
      CSR_SCREEN_ROWS = 3'd4
   } csr_index_type;

   typedef struct packed {
      coord_type rem;
      logic qbit;
   } div_step_type;

   // one restoring step: shift in a numerator bit, subtract when it fits
   function automatic div_step_type div_step(input coord_type rem, input logic nbit,
                                             input coord_type divisor);
      logic [COORD_W:0] trial;
      div_step_type res;
      trial = {rem, nbit};
      if (trial >= {1'b0, divisor}) begin
         res.rem = COORD_W'(trial - {1'b0, divisor});
         res.qbit = 1'b1;
      end else begin
         res.rem = trial[COORD_W-1:0];
         res.qbit = 1'b0;
      end
      return res;
   endfunction

endpackage

FILE: rtl/core/tpcs_divider.sv
// ----------------------------------------------------------------------------
// tpcs_divider
// pipelined restoring divider, one quotient bit per stage; the quotient is
// known to fit in COORD_W bits, so the upper numerator half seeds the remainder
// ----------------------------------------------------------------------------
module tpcs_divider (
   input  logic                                clock,
   input  logic [tpcs_pkg::DIV_STEPS-1:0]      stage_en,
   input  tpcs_pkg::numer_type                 numer,
   input  tpcs_pkg::coord_type                 divisor,
   output tpcs_pkg::coord_type                 quotient
);
   import tpcs_pkg::*;

   coord_type rem_src [DIV_STEPS];
   coord_type nq_src [DIV_STEPS];
   div_step_type step_res [DIV_STEPS];
   coord_type nq_in [DIV_STEPS];
   coord_type nq_ff [DIV_STEPS];
   coord_type rem_ff [DIV_STEPS-1];

   assign rem_src[0] = numer[NUMER_W-1:COORD_W];
   assign nq_src[0] = numer[COORD_W-1:0];

   genvar k;
   generate
      for (k = 0; k < DIV_STEPS; k++) begin : g_step
         if (k > 0) begin : g_src
            assign rem_src[k] = rem_ff[k-1];
            assign nq_src[k] = nq_ff[k-1];
         end
         assign step_res[k] = div_step(rem_src[k], nq_src[k][COORD_W-1], divisor);
         // numerator bits leave at the top, quotient bits enter at the bottom
         assign nq_in[k] = {nq_src[k][COORD_W-2:0], step_res[k].qbit};

         always_ff @(posedge clock) begin
            if (stage_en[k]) begin
               nq_ff[k] <= nq_in[k];
            end
         end

         if (k < DIV_STEPS - 1) begin : g_rem
            always_ff @(posedge clock) begin
               if (stage_en[k]) begin
                  rem_ff[k] <= step_res[k].rem;
               end
            end
         end
      end
   endgenerate

   assign quotient = nq_ff[DIV_STEPS-1];

endmodule

FILE: rtl/core/tablet_packet_coordinate_scaler_core.sv
// ----------------------------------------------------------------------------
// tablet_packet_coordinate_scaler_core
// absolute tablet packet decode with clamp and screen / absolute scaling
// ----------------------------------------------------------------------------
// usage:
//   req_ carries one five-byte packet per transaction (status byte and the
//   7-bit halves of x and y); rsp_ carries screen_x, screen_y, abs_x, abs_y
//   and the three button flags. csr_ writes border, max_x, max_y,
//   screen_cols and screen_rows by index 0 to 4; csr_ready is always high.
//   pipeline: each transaction passes through 17 register stages: clamp
//   stage, multiply stage, 14 divider stages, output register.
//   throughput: one transaction per cycle while rsp_tready does not hold
//   the result, set by the one-bit-per-stage restoring dividers, four of
//   them running side by side.
//   reset clears all stage valid bits and loads the register defaults.
//   when rsp_tready is low the result holds; earlier stages keep moving
//   until they reach an occupied stage, so req_tready only drops once the
//   pipeline has no empty stage left. write registers only when no
//   transaction is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tablet_packet_coordinate_scaler_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // status_byte[7:0], x_low[14:8], x_high[21:15], y_low[28:22], y_high[35:29]
   input  logic [tpcs_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // screen_x[9:0], screen_y[19:10], abs_x[33:20], abs_y[47:34],
   // button_left[48], button_right[49], button_middle[50]
   output logic [tpcs_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  tpcs_pkg::csr_index_type              csr_index,
   input  logic [tpcs_pkg::COORD_W-1:0]         csr_data
);
   import tpcs_pkg::*;

   localparam int STAGES = DIV_STEPS + 3;
   localparam int OUT_STAGE = STAGES - 1;
   localparam int DIV_FIRST = 2;

   // config registers
   coord_type border_ff, max_x_ff, max_y_ff;
   screen_type cols_ff, rows_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         border_ff <= BORDER_RESET;
         max_x_ff <= MAX_RESET;
         max_y_ff <= MAX_RESET;
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BORDER: border_ff <= csr_data;
            CSR_MAX_X: max_x_ff <= csr_data;
            CSR_MAX_Y: max_y_ff <= csr_data;
            CSR_SCREEN_COLS: cols_ff <= csr_data[SCREEN_W-1:0];
            CSR_SCREEN_ROWS: rows_ff <= csr_data[SCREEN_W-1:0];
            default: ;
         endcase
      end
   end

   // stage valid bits and per-stage advance
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] adv;
   logic [STAGES-1:0] valid_in;

   always_comb begin
      adv[OUT_STAGE] = !valid_ff[OUT_STAGE] || rsp_tready;
      for (int i = OUT_STAGE - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_in[0] = adv[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = adv[0];

   // stage 0: assemble, remove border, clamp
   logic [7:0] status_byte;
   coord_type raw_x, raw_y, cx_in, cy_in, cx_ff, cy_ff;
   btn_type btn_ff [OUT_STAGE];

   assign status_byte = req_tdata[7:0];
   assign raw_x = {req_tdata[21:15], req_tdata[14:8]};
   assign raw_y = {req_tdata[35:29], req_tdata[28:22]};

   function automatic coord_type clamp_coord(input coord_type raw, input coord_type border,
                                             input coord_type limit);
      coord_type v;
      v = (raw > border) ? COORD_W'(raw - border) : '0;
      if (v > limit) begin
         v = limit;
      end
      return v;
   endfunction

   assign cx_in = clamp_coord(raw_x, border_ff, max_x_ff);
   assign cy_in = clamp_coord(raw_y, border_ff, max_y_ff);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         btn_ff[0] <= status_byte[BTN_W-1:0];
      end
   end

   // button flags ride alongside the arithmetic
   genvar s;
   generate
      for (s = 1; s < OUT_STAGE; s++) begin : g_btn
         always_ff @(posedge clock) begin
            if (adv[s]) begin
               btn_ff[s] <= btn_ff[s-1];
            end
         end
      end
   endgenerate

   // stage 1: products
   screen_type rows_m1;
   numer_type sx_num_in, sy_num_in, ax_num_in, ay_num_in;
   numer_type sx_num_ff, sy_num_ff, ax_num_ff, ay_num_ff;

   assign rows_m1 = (rows_ff == '0) ? '0 : SCREEN_W'(rows_ff - 1'b1);
   assign sx_num_in = NUMER_W'(cx_ff) * NUMER_W'(cols_ff);
   assign sy_num_in = NUMER_W'(cy_ff) * NUMER_W'(rows_m1);
   assign ax_num_in = NUMER_W'(cx_ff) * NUMER_W'(ABS_FULL);
   assign ay_num_in = NUMER_W'(cy_ff) * NUMER_W'(ABS_FULL);

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         sx_num_ff <= sx_num_in;
         sy_num_ff <= sy_num_in;
         ax_num_ff <= ax_num_in;
         ay_num_ff <= ay_num_in;
      end
   end

   // stages 2 to 15: dividers
   logic [DIV_STEPS-1:0] div_en;
   coord_type sx_q, sy_q, ax_q, ay_q;

   assign div_en = adv[DIV_FIRST +: DIV_STEPS];

   tpcs_divider u_div_sx (
      .clock(clock), .stage_en(div_en), .numer(sx_num_ff), .divisor(max_x_ff),
      .quotient(sx_q)
   );
   tpcs_divider u_div_sy (
      .clock(clock), .stage_en(div_en), .numer(sy_num_ff), .divisor(max_y_ff),
      .quotient(sy_q)
   );
   tpcs_divider u_div_ax (
      .clock(clock), .stage_en(div_en), .numer(ax_num_ff), .divisor(max_x_ff),
      .quotient(ax_q)
   );
   tpcs_divider u_div_ay (
      .clock(clock), .stage_en(div_en), .numer(ay_num_ff), .divisor(max_y_ff),
      .quotient(ay_q)
   );

   // output register; a zero maximum skips the division
   logic zero_x, zero_y;
   screen_type screen_x_in, screen_y_in, screen_x_ff, screen_y_ff;
   coord_type abs_x_in, abs_y_in, abs_x_ff, abs_y_ff;
   btn_type btn_out_ff;

   assign zero_x = (max_x_ff == '0);
   assign zero_y = (max_y_ff == '0);
   assign screen_x_in = zero_x ? '0 : sx_q[SCREEN_W-1:0];
   assign screen_y_in = SCREEN_W'(1) + (zero_y ? SCREEN_W'(0) : sy_q[SCREEN_W-1:0]);
   assign abs_x_in = zero_x ? '0 : ax_q;
   assign abs_y_in = zero_y ? '0 : ay_q;

   always_ff @(posedge clock) begin
      if (adv[OUT_STAGE]) begin
         screen_x_ff <= screen_x_in;
         screen_y_ff <= screen_y_in;
         abs_x_ff <= abs_x_in;
         abs_y_ff <= abs_y_in;
         btn_out_ff <= btn_ff[OUT_STAGE-1];
      end
   end

   assign rsp_tvalid = valid_ff[OUT_STAGE];
   assign rsp_tdata = {5'b0, btn_out_ff, abs_y_ff, abs_x_ff, screen_y_ff, screen_x_ff};

   // checks
   `ASSERT_CLK_RST(a_full_stalls_input, clock, reset,
      (&valid_ff && !rsp_tready) |-> !req_tready, "input taken with pipeline full")
   `ASSERT_CLK_RST(a_count_in, clock, reset,
      (req_tvalid && req_tready && !(rsp_tvalid && rsp_tready)) |=>
         ($countones(valid_ff) == $past($countones(valid_ff)) + 1),
      "transaction lost or duplicated on entry")
   `ASSERT_CLK_RST(a_count_out, clock, reset,
      (!(req_tvalid && req_tready) && rsp_tvalid && rsp_tready) |=>
         ($countones(valid_ff) + 1 == $past($countones(valid_ff))),
      "transaction lost or duplicated on exit")
   `ASSERT_CLK(a_zero_max_x, clock,
      (rsp_tvalid && max_x_ff == '0) |-> (screen_x_ff == '0 && abs_x_ff == '0),
      "zero max_x gave nonzero x")

endmodule

FILE: tb/sv/tb_tablet_packet_coordinate_scaler_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tablet_packet_coordinate_scaler_core
// checks packet decode, border removal, clamping, screen and absolute scaling
// and the button flags against an independent prediction. directed packets at
// the register and coordinate extremes come first, then random packets over
// several random register settings, with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb_tablet_packet_coordinate_scaler_core;
   import tpcs_pkg::*;

   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_CYCLES = 24;
   localparam int MAX_GAP = 8;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_PACKETS = 178;
   localparam int CSR_REG_COUNT = 5;
   localparam int CSR_INDEX_LIMIT = 8;
   localparam longint TIMEOUT_NS = 2_000_000;

   // status lowest, then the x and y halves
   typedef struct packed {
      logic [6:0] y_high;
      logic [6:0] y_low;
      logic [6:0] x_high;
      logic [6:0] x_low;
      logic [7:0] status;
   } tablet_packet_type;

   typedef struct packed {
      logic       button_middle;
      logic       button_right;
      logic       button_left;
      coord_type  abs_y;
      coord_type  abs_x;
      screen_type screen_y;
      screen_type screen_x;
   } tablet_report_type;

   typedef struct {
      coord_type  border;
      coord_type  max_x;
      coord_type  max_y;
      screen_type cols;
      screen_type rows;
   } scaler_cfg_type;

   localparam int REPORT_W = $bits(tablet_report_type);

   logic clock = 1'b0;
   logic reset;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic req_tvalid;
   logic req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic csr_valid;
   logic csr_ready;
   csr_index_type csr_index;
   coord_type csr_data;

   scaler_cfg_type cfg;
   tablet_report_type expected_reports[$];
   bit idle_on = 1'b1;
   int error_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int settings_count = 0;

   tablet_packet_coordinate_scaler_core dut (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_gap();
      if (!idle_on) return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic int unsigned scaled_coord(input int unsigned v, input int unsigned mul,
                                                input int unsigned div);
      if (div == 0) return 0;
      return (v * mul) / div;
   endfunction

   function automatic int unsigned clamp_coord(input int unsigned raw, input int unsigned lim);
      int unsigned v;
      v = (raw > cfg.border) ? raw - cfg.border : 0;
      if (v > lim) v = lim;
      return v;
   endfunction

   function automatic tablet_report_type predict_report(input tablet_packet_type p);
      int unsigned cx;
      int unsigned cy;
      int unsigned rows_m1;
      tablet_report_type r;
      cx = clamp_coord({p.x_high, p.x_low}, cfg.max_x);
      cy = clamp_coord({p.y_high, p.y_low}, cfg.max_y);
      rows_m1 = (cfg.rows > 0) ? cfg.rows - 1 : 0;
      r.screen_x = screen_type'(scaled_coord(cx, cfg.cols, cfg.max_x));
      r.screen_y = screen_type'(1 + scaled_coord(cy, rows_m1, cfg.max_y));
      r.abs_x = coord_type'(scaled_coord(cx, ABS_FULL, cfg.max_x));
      r.abs_y = coord_type'(scaled_coord(cy, ABS_FULL, cfg.max_y));
      r.button_left = p.status[0];
      r.button_right = p.status[1];
      r.button_middle = p.status[2];
      return r;
   endfunction

   function automatic tablet_packet_type make_packet(input logic [7:0] status,
                                                     input coord_type raw_x,
                                                     input coord_type raw_y);
      tablet_packet_type p;
      p.status = status;
      p.x_low = raw_x[6:0];
      p.x_high = raw_x[13:7];
      p.y_low = raw_y[6:0];
      p.y_high = raw_y[13:7];
      return p;
   endfunction

   // raw coordinate biased toward the border and the clamp edge
   function automatic coord_type pick_raw(input coord_type lim);
      int unsigned base;
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: begin
            base = cfg.border;
            return coord_type'(base + $urandom_range(0, 6) - 3);
         end
         3: begin
            base = cfg.border + lim;
            return coord_type'(base + $urandom_range(0, 6) - 3);
         end
         default: return coord_type'($urandom());
      endcase
   endfunction

   function automatic coord_type pick_limit(input int unsigned hi);
      case ($urandom_range(0, 15))
         0: return '0;
         1, 2: return coord_type'(1);
         3, 4: return coord_type'(hi);
         5, 6: return coord_type'($urandom_range(1, 63));
         7: return coord_type'($urandom());
         default: return coord_type'($urandom_range(1, hi));
      endcase
   endfunction

   function automatic coord_type pick_border();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return BORDER_RESET;
         2: return '1;
         3, 4: return coord_type'($urandom_range(0, 300));
         default: return coord_type'($urandom());
      endcase
   endfunction

   task automatic write_csr(input int idx, input coord_type data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= csr_index_type'(idx);
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (csr_index_type'(idx))
         CSR_BORDER: cfg.border = data;
         CSR_MAX_X: cfg.max_x = data;
         CSR_MAX_Y: cfg.max_y = data;
         CSR_SCREEN_COLS: cfg.cols = data[SCREEN_W-1:0];
         CSR_SCREEN_ROWS: cfg.rows = data[SCREEN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input coord_type border, input coord_type mx, input coord_type my,
                             input coord_type cols, input coord_type rows);
      write_csr(CSR_BORDER, border);
      write_csr(CSR_MAX_X, mx);
      write_csr(CSR_MAX_Y, my);
      write_csr(CSR_SCREEN_COLS, cols);
      write_csr(CSR_SCREEN_ROWS, rows);
      settings_count++;
   endtask

   task automatic send_packet(input tablet_packet_type p);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata <= REQ_DATA_W'({$urandom(), $urandom()});
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'(p);
      do @(posedge clock); while (!req_tready);
      expected_reports.push_back(predict_report(p));
      sent_count++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_default_extremes();
      send_packet(make_packet(8'h00, 14'd0, 14'd0));
      send_packet(make_packet(8'hff, 14'h3fff, 14'h3fff));
      send_packet(make_packet(8'h01, BORDER_RESET, BORDER_RESET + 14'd1));
      send_packet(make_packet(8'h02, BORDER_RESET + 14'd1, BORDER_RESET));
      send_packet(make_packet(8'h04, BORDER_RESET - 14'd1, 14'h3fff));
      // unused status bits only
      send_packet(make_packet(8'hf8, 14'h2aaa, 14'h1555));
      wait_idle();
   endtask

   task automatic test_register_extremes();
      set_config(14'd0, MAX_RESET, MAX_RESET, 14'd1023, 14'd1023);
      send_packet(make_packet(8'h07, 14'd0, 14'h3fff));
      send_packet(make_packet(8'h00, 14'h3fff, 14'd0));
      wait_idle();
      // border swallows every coordinate
      set_config(14'h3fff, MAX_RESET, MAX_RESET, 14'd1023, 14'd1023);
      send_packet(make_packet(8'h03, 14'h3fff, 14'h3ffe));
      wait_idle();
      set_config(14'd0, 14'd1, 14'd1, 14'd1, 14'd1);
      send_packet(make_packet(8'h05, 14'd0, 14'd1));
      send_packet(make_packet(8'h06, 14'd2, 14'h3fff));
      wait_idle();
      // zero maximum skips the division
      set_config(14'd10, 14'd0, 14'd0, 14'd1023, 14'd1023);
      send_packet(make_packet(8'h01, 14'h3fff, 14'd500));
      wait_idle();
      // zero screen size
      set_config(14'd0, MAX_RESET, MAX_RESET, 14'd0, 14'd0);
      send_packet(make_packet(8'h02, 14'd8000, 14'h3fff));
      wait_idle();
   endtask

   task automatic test_unused_index();
      set_config(14'd50, 14'd9000, 14'd7000, 14'd640, 14'd480);
      for (int idx = CSR_REG_COUNT; idx < CSR_INDEX_LIMIT; idx++)
         write_csr(idx, coord_type'($urandom()));
      send_packet(make_packet(8'h07, 14'h3fff, 14'h3fff));
      wait_idle();
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_config(pick_border(), pick_limit(MAX_RESET), pick_limit(MAX_RESET),
                    pick_limit(1023), pick_limit(1023));
         for (int n = 0; n < PHASE_PACKETS; n++) begin
            if (n % 32 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_packet(make_packet(8'($urandom()), pick_raw(cfg.max_x), pick_raw(cfg.max_y)));
         end
         idle_on = 1'b1;
         wait_idle();
      end
   endtask

   always @(posedge clock) begin : check_results
      tablet_report_type got;
      tablet_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[REPORT_W-1:0];
         if (expected_reports.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected result transaction: %h", got);
         end else begin
            want = expected_reports.pop_front();
            checked_count++;
            if (got.screen_x != want.screen_x || got.screen_y != want.screen_y ||
                got.abs_x != want.abs_x || got.abs_y != want.abs_y ||
                got.button_left != want.button_left ||
                got.button_right != want.button_right ||
                got.button_middle != want.button_middle) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display({"mismatch at %0t: expected sx %0d sy %0d ax %0d ay %0d btn %b%b%b,",
                            " got sx %0d sy %0d ax %0d ay %0d btn %b%b%b"},
                           $time, want.screen_x, want.screen_y, want.abs_x, want.abs_y,
                           want.button_middle, want.button_right, want.button_left,
                           got.screen_x, got.screen_y, got.abs_x, got.abs_y,
                           got.button_middle, got.button_right, got.button_left);
            end
         end
      end
   end

   initial begin : drive_rsp_ready
      int gap;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d results outstanding", expected_reports.size());
      $display("tb_tablet_packet_coordinate_scaler_core failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = CSR_BORDER;
      csr_data = '0;
      cfg.border = BORDER_RESET;
      cfg.max_x = MAX_RESET;
      cfg.max_y = MAX_RESET;
      cfg.cols = COLS_RESET;
      cfg.rows = ROWS_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_default_extremes();
      test_register_extremes();
      test_unused_index();
      test_random_settings();
      wait_idle();

      $display("sent %0d packets, checked %0d results over %0d register settings",
               sent_count, checked_count, settings_count + 1);
      $display("covered border clamp, zero maximum and screen size, unused index writes");
      if (error_count == 0) begin
         $display("tb_tablet_packet_coordinate_scaler_core passed");
      end else begin
         $display("%0d errors", error_count);
         $display("tb_tablet_packet_coordinate_scaler_core failed");
      end
      $finish;
   end

endmodule
